// ----- sv/rolt_pkg.sv -----
// Shared constants and the controller/datapath command and status types for the orbit landing tracker.
package rolt_pkg;

  localparam int unsigned VALUE_BITS_DEF = 20;
  localparam int unsigned WORD_BITS      = 64;
  localparam int unsigned BIT_SEL_BITS   = 6;

  typedef struct packed {
    logic clr_run;
    logic begin_tick;
    logic set_ovf;
    logic val_ovf;
    logic take;
    logic rd_mark;
    logic mark_wr;
    logic div_start;
    logic div_step;
    logic commit;
    logic load_out;
  } rolt_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic ovf;
    logic tick_max;
    logic sum_ovf;
    logic div_last;
    logic out_busy;
  } rolt_sts_t;

endpackage

// ----- sv/rolt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module rolt_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/rolt_ctrl.sv -----
// Sequencer that steps one orbit tick through probe, mark, divide and commit.
module rolt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               in_valid_i,
  input  logic               advance_i,
  output logic               in_stall_o,
  input  rolt_pkg::rolt_sts_t sts_i,
  output rolt_pkg::rolt_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    StClear, StIdle, StProbeRd, StProbeChk, StMarkRd, StMarkWr, StDiv, StArc, StEmit
  } state_e;

  state_e state_q, state_d;
  logic   acc_adv;

  assign in_stall_o = (state_q != StIdle);
  assign acc_adv    = (state_q == StIdle) && in_valid_i && advance_i;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      StClear: begin
        cmd_o.clr_run = 1'b1;
        if (sts_i.clr_last) state_d = StIdle;
      end
      StIdle: begin
        if (acc_adv) begin
          cmd_o.begin_tick = 1'b1;
          if (sts_i.ovf) begin
            state_d = StEmit;
          end else if (sts_i.tick_max) begin
            cmd_o.set_ovf = 1'b1;
            state_d       = StEmit;
          end else begin
            state_d = StProbeRd;
          end
        end
      end
      StProbeRd: state_d = StProbeChk;
      StProbeChk: begin
        if (sts_i.sum_ovf) begin
          cmd_o.val_ovf = 1'b1;
          state_d       = StEmit;
        end else begin
          cmd_o.take = 1'b1;
          state_d    = StMarkRd;
        end
      end
      StMarkRd: begin
        cmd_o.rd_mark = 1'b1;
        state_d       = StMarkWr;
      end
      StMarkWr: begin
        cmd_o.mark_wr   = 1'b1;
        cmd_o.div_start = 1'b1;
        state_d         = StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = StArc;
      end
      StArc: begin
        cmd_o.commit = 1'b1;
        state_d      = StEmit;
      end
      StEmit: begin
        if (!sts_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
    if (cfg_we_i) begin
      cmd_o   = '0;
      state_d = StClear;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- sv/rolt_dp.sv -----
// Orbit state, visited bitmap, restoring divider, arc tracking and output word register.
module rolt_dp #(
  parameter int unsigned VALUE_BITS = rolt_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [VALUE_BITS-1:0] start_value_i,
  input  rolt_pkg::rolt_cmd_t   cmd_i,
  output rolt_pkg::rolt_sts_t   sts_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [VALUE_BITS-1:0] step_index_o,
  output logic [VALUE_BITS-1:0] term_value_o,
  output logic                  landing_valid_o,
  output logic [VALUE_BITS-1:0] landing_index_o,
  output logic [VALUE_BITS-1:0] landing_value_o,
  output logic                  overflow_o
);

  localparam int unsigned VB    = VALUE_BITS;
  localparam int unsigned SB    = rolt_pkg::BIT_SEL_BITS;
  localparam int unsigned WB    = rolt_pkg::WORD_BITS;
  localparam int unsigned AW    = VB - SB;
  localparam int unsigned DEPTH = 1 << AW;
  localparam int unsigned CW    = $clog2(VB);

  logic [VB-1:0] start_q, cur_q, tick_q, last_res_q, low_val_q, low_idx_q, n_q, nv_q;
  logic          arc_open_q, ovf_q;
  logic          land_valid_q;
  logic [VB-1:0] land_idx_q, land_val_q;
  logic [AW-1:0] clr_addr_q;
  logic [VB-1:0] rem_q, dvd_q;
  logic [CW-1:0] cnt_q;

  logic          out_valid_q, out_land_q, out_ovf_q;
  logic [VB-1:0] out_idx_q, out_val_q, out_lidx_q, out_lval_q;

  logic [VB-1:0] diff;
  logic [VB:0]   sum, trial;
  logic          down, close;
  logic [AW-1:0] raddr, waddr;
  logic [WB-1:0] wdata, rdata;
  logic          we;

  assign diff  = cur_q - n_q;
  assign sum   = {1'b0, cur_q} + {1'b0, n_q};
  assign down  = (cur_q > n_q) && !rdata[diff[SB-1:0]];
  assign trial = {rem_q, dvd_q[VB-1]};
  assign close = arc_open_q && (rem_q > last_res_q);

  assign raddr = cmd_i.rd_mark ? nv_q[VB-1:SB] : diff[VB-1:SB];
  assign we    = cmd_i.clr_run || cmd_i.mark_wr;
  assign waddr = cmd_i.clr_run ? clr_addr_q : nv_q[VB-1:SB];
  always_comb begin
    if (cmd_i.clr_run) begin
      wdata = (clr_addr_q == start_q[VB-1:SB]) ? (WB'(1) << start_q[SB-1:0]) : '0;
    end else begin
      wdata = rdata | (WB'(1) << nv_q[SB-1:0]);
    end
  end

  rolt_ram #(.Width(WB), .Depth(DEPTH)) u_map (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign sts_o.clr_last = &clr_addr_q;
  assign sts_o.ovf      = ovf_q;
  assign sts_o.tick_max = &tick_q;
  assign sts_o.sum_ovf  = !down && sum[VB];
  assign sts_o.div_last = (cnt_q == CW'(VB - 1));
  assign sts_o.out_busy = out_valid_q && out_stall_i;

  // Orbit and arc state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q      <= '0;
      cur_q        <= '0;
      tick_q       <= '0;
      last_res_q   <= '0;
      arc_open_q   <= 1'b0;
      low_val_q    <= '0;
      low_idx_q    <= '0;
      ovf_q        <= 1'b0;
      land_valid_q <= 1'b0;
      clr_addr_q   <= '0;
    end else if (cfg_we_i) begin
      start_q    <= start_value_i;
      cur_q      <= start_value_i;
      tick_q     <= '0;
      last_res_q <= '0;
      arc_open_q <= 1'b0;
      low_val_q  <= '0;
      low_idx_q  <= '0;
      ovf_q      <= 1'b0;
      clr_addr_q <= '0;
    end else begin
      if (cmd_i.clr_run) clr_addr_q <= clr_addr_q + AW'(1);
      if (cmd_i.begin_tick) land_valid_q <= 1'b0;
      if (cmd_i.set_ovf) ovf_q <= 1'b1;
      if (cmd_i.val_ovf) begin
        ovf_q  <= 1'b1;
        tick_q <= n_q;
      end
      if (cmd_i.commit) begin
        land_valid_q <= close;
        cur_q        <= nv_q;
        tick_q       <= n_q;
        last_res_q   <= rem_q;
        arc_open_q   <= 1'b1;
        if (close || !arc_open_q || (nv_q < low_val_q)) begin
          low_val_q <= nv_q;
          low_idx_q <= n_q;
        end
      end
    end
  end

  // Payload registers of the tick in flight
  always_ff @(posedge clk_i) begin
    if (cmd_i.begin_tick) n_q <= tick_q + VB'(1);
    if (cmd_i.take) nv_q <= down ? diff : sum[VB-1:0];
    if (cmd_i.commit) begin
      land_idx_q <= close ? low_idx_q : '0;
      land_val_q <= close ? low_val_q : '0;
    end
    if (cmd_i.div_start) begin
      rem_q <= '0;
      dvd_q <= nv_q;
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= (trial >= {1'b0, n_q}) ? VB'(trial - {1'b0, n_q}) : trial[VB-1:0];
      dvd_q <= {dvd_q[VB-2:0], 1'b0};
      cnt_q <= cnt_q + CW'(1);
    end
  end

  // Output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_idx_q  <= tick_q;
      out_val_q  <= cur_q;
      out_land_q <= land_valid_q;
      out_lidx_q <= land_valid_q ? land_idx_q : '0;
      out_lval_q <= land_valid_q ? land_val_q : '0;
      out_ovf_q  <= ovf_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign step_index_o    = out_idx_q;
  assign term_value_o    = out_val_q;
  assign landing_valid_o = out_land_q;
  assign landing_index_o = out_lidx_q;
  assign landing_value_o = out_lval_q;
  assign overflow_o      = out_ovf_q;

endmodule

// ----- sv/recaman_orbit_landing_tracker_unit.sv -----
// Top level of the orbit landing tracker: sequencer, datapath and checks.
//
// Each accepted input word with advance high computes one more orbit term and
// produces one output word; a word with advance low is taken and dropped.
// A normal tick runs from acceptance to the output register through two
// bitmap reads (probe of the downward candidate and read-modify-write of the
// new term's bit) and a restoring divider that forms value mod index one
// quotient bit per cycle. A tick after overflow, or one that overflows,
// skips the bitmap write and the divider.
// Input stall stays high while a tick is in flight; a finished word waits in
// the output register and does not block the next input. After reset, and
// after every write of start_value (which restarts the orbit), the visited
// bitmap is cleared by a sweep of all 2^(VALUE_BITS-6) words (16384 at the
// default), one 64-bit word per cycle, with the start value's bit set on the
// way; input stays stalled during that sweep. Write start_value only while
// the block is idle. Overflow is sticky until the next start_value write.
module recaman_orbit_landing_tracker_unit #(
  parameter int unsigned VALUE_BITS = rolt_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [VALUE_BITS-1:0] start_value_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  advance_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [VALUE_BITS-1:0] step_index_o,
  output logic [VALUE_BITS-1:0] term_value_o,
  output logic                  landing_valid_o,
  output logic [VALUE_BITS-1:0] landing_index_o,
  output logic [VALUE_BITS-1:0] landing_value_o,
  output logic                  overflow_o
);

  rolt_pkg::rolt_cmd_t cmd;
  rolt_pkg::rolt_sts_t sts;

  rolt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .in_valid_i (in_valid_i),
    .advance_i  (advance_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rolt_dp #(.VALUE_BITS(VALUE_BITS)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .start_value_i   (start_value_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .step_index_o    (step_index_o),
    .term_value_o    (term_value_o),
    .landing_valid_o (landing_valid_o),
    .landing_index_o (landing_index_o),
    .landing_value_o (landing_value_o),
    .overflow_o      (overflow_o)
  );

`ifndef SYNTH
  // A landing always points back to an earlier term of the orbit
  a_land_before: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && landing_valid_o) |-> (landing_index_o < step_index_o))
    else $error("landing index not before step index");

  // A frozen orbit never reports a landing
  a_ovf_no_land: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && overflow_o) |-> !landing_valid_o)
    else $error("landing reported with overflow");

  // A good word always carries a computed term
  a_index_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !overflow_o) |-> (step_index_o != '0))
    else $error("zero step index without overflow");
`endif

endmodule

// ----- bench/tb_top.sv -----
// Self-checking testbench for the orbit landing tracker: directed table, then random phases.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned VB        = rolt_pkg::VALUE_BITS_DEF;
  localparam longint      VMASK     = (64'd1 << VB) - 1;
  localparam longint      LIMIT     = 3000000;
  localparam int unsigned TAIL      = 60;
  localparam int unsigned HOLD_LEN  = 3000;
  localparam int unsigned PER_PHASE = 305;

  typedef enum logic [0:0] {ROW_TICK, ROW_CFG} row_op_e;

  typedef struct packed {
    logic [VB-1:0] step_index;
    logic [VB-1:0] term_value;
    logic          landing_valid;
    logic [VB-1:0] landing_index;
    logic [VB-1:0] landing_value;
    logic          overflow;
  } orbit_word_t;

  typedef struct {
    row_op_e       op;
    logic [VB-1:0] cfg_value;
    bit            adv;
    bit            typed;
    orbit_word_t   want;
  } stim_row_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          cfg_we = 1'b0;
  logic [VB-1:0] start_value = '0;
  logic          in_valid = 1'b0;
  logic          advance = 1'b0;
  logic          out_stall = 1'b0;
  logic          in_stall, out_valid;
  logic [VB-1:0] step_index, term_value, landing_index, landing_value;
  logic          landing_valid, overflow;

  // Predictor state: visited set plus orbit and arc registers.
  bit            seen_map [0:(1<<VB)-1];
  logic [VB-1:0] orb_start, orb_value, orb_index, last_res, low_val, low_idx;
  bit            arc_live, orb_ovf;

  orbit_word_t   expect_q [$];
  bit            cur_typed = 1'b0;
  orbit_word_t   cur_want = '0;
  bit            failed = 1'b0;
  longint        cycles = 0;
  int unsigned   idle_pct = 0;
  int unsigned   stall_pct = 0;
  bit            hold_req = 1'b0;
  int unsigned   hold_left = 0;
  stim_row_t     rows [$];

  always #5 clk = ~clk;

  recaman_orbit_landing_tracker_unit u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .start_value_i   (start_value),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .advance_i       (advance),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .step_index_o    (step_index),
    .term_value_o    (term_value),
    .landing_valid_o (landing_valid),
    .landing_index_o (landing_index),
    .landing_value_o (landing_value),
    .overflow_o      (overflow)
  );

  task automatic restart_orbit();
    foreach (seen_map[i]) seen_map[i] = 1'b0;
    seen_map[orb_start] = 1'b1;
    orb_value = orb_start;
    orb_index = '0;
    last_res  = '0;
    arc_live  = 1'b0;
    low_val   = '0;
    low_idx   = '0;
    orb_ovf   = 1'b0;
  endtask

  // Compute the next orbit term and the landing it may close.
  task automatic advance_orbit(output orbit_word_t w);
    longint n, v, nv, r;
    bit     down;
    w = '0;
    if (!orb_ovf) begin
      n = longint'(orb_index) + 1;
      if (n > VMASK) begin
        orb_ovf = 1'b1;
      end else begin
        v    = longint'(orb_value);
        down = (v > n) && !seen_map[v - n];
        nv   = down ? v - n : v + n;
        if (nv > VMASK) begin
          // value overflow: index moves, value and arc hold
          orb_ovf   = 1'b1;
          orb_index = n[VB-1:0];
        end else begin
          r = nv % n;
          seen_map[nv] = 1'b1;
          orb_value = nv[VB-1:0];
          orb_index = n[VB-1:0];
          if (arc_live && r > longint'(last_res)) begin
            w.landing_valid = 1'b1;
            w.landing_index = low_idx;
            w.landing_value = low_val;
            arc_live = 1'b0;
          end
          if (!arc_live) begin
            arc_live = 1'b1;
            low_val  = nv[VB-1:0];
            low_idx  = n[VB-1:0];
          end else if (nv < longint'(low_val)) begin
            low_val = nv[VB-1:0];
            low_idx = n[VB-1:0];
          end
          last_res = r[VB-1:0];
        end
      end
    end
    w.step_index = orb_index;
    w.term_value = orb_value;
    w.overflow   = orb_ovf;
  endtask

  // Predict on every accepted advance word; a typed table row overrides.
  always @(posedge clk) begin
    orbit_word_t w;
    if (rst_n && in_valid && !in_stall && advance) begin
      advance_orbit(w);
      if (cur_typed) w = cur_want;
      expect_q = {expect_q, w};
    end
  end

  // Compare each accepted output word against the oldest expectation.
  always @(posedge clk) begin
    orbit_word_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expect_q.size() == 0) begin
        $error("output word with nothing expected");
        failed = 1'b1;
      end else begin
        e = expect_q.pop_front();
        if (step_index !== e.step_index) begin
          $error("step_index exp %0d got %0d", e.step_index, step_index); failed = 1'b1;
        end
        if (term_value !== e.term_value) begin
          $error("term_value exp %0d got %0d", e.term_value, term_value); failed = 1'b1;
        end
        if (landing_valid !== e.landing_valid) begin
          $error("landing_valid exp %0d got %0d", e.landing_valid, landing_valid);
          failed = 1'b1;
        end
        if (landing_index !== e.landing_index) begin
          $error("landing_index exp %0d got %0d", e.landing_index, landing_index);
          failed = 1'b1;
        end
        if (landing_value !== e.landing_value) begin
          $error("landing_value exp %0d got %0d", e.landing_value, landing_value);
          failed = 1'b1;
        end
        if (overflow !== e.overflow) begin
          $error("overflow exp %0d got %0d", e.overflow, overflow); failed = 1'b1;
        end
      end
    end
  end

  // Receiver: random stall, or a long counted hold-off on request.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Offer one word; return once it is accepted.
  task automatic send_word(bit adv, bit typed, orbit_word_t want);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid  = 1'b1;
    advance   = adv;
    cur_typed = typed;
    cur_want  = want;
    do @(posedge clk); while (in_stall);
  endtask

  // Drain the expected words, pause, then restart the orbit.
  task automatic write_start(logic [VB-1:0] value);
    @(negedge clk);
    in_valid = 1'b0;
    while (expect_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    @(negedge clk);
    cfg_we      = 1'b1;
    start_value = value;
    orb_start   = value;
    restart_orbit();
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic void add_row(stim_row_t r);
    rows = {rows, r};
  endfunction

  function automatic stim_row_t tick_row(bit adv, bit typed, orbit_word_t want);
    stim_row_t r;
    r.op = ROW_TICK; r.cfg_value = '0; r.adv = adv; r.typed = typed; r.want = want;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic [VB-1:0] value);
    stim_row_t r;
    r.op = ROW_CFG; r.cfg_value = value; r.adv = 1'b0; r.typed = 1'b0; r.want = '0;
    return r;
  endfunction

  function automatic orbit_word_t mk(int si, int tv, bit lv, int li, int lval);
    orbit_word_t w;
    w.step_index = VB'(si); w.term_value = VB'(tv); w.landing_valid = lv;
    w.landing_index = VB'(li); w.landing_value = VB'(lval); w.overflow = 1'b0;
    return w;
  endfunction

  initial begin
    logic [VB-1:0] phase_start [5];
    int unsigned   done_ticks;
    bit            adv;

    orb_start = '0;
    restart_orbit();

    // Directed table: orbit from reset start 0, ignored words, extreme starts.
    add_row(tick_row(1'b0, 1'b0, '0));
    add_row(tick_row(1'b1, 1'b1, mk(1, 1, 1'b0, 0, 0)));
    add_row(tick_row(1'b1, 1'b1, mk(2, 3, 1'b1, 1, 1)));
    add_row(tick_row(1'b0, 1'b0, '0));
    add_row(tick_row(1'b1, 1'b1, mk(3, 6, 1'b0, 0, 0)));
    add_row(tick_row(1'b1, 1'b1, mk(4, 2, 1'b1, 2, 3)));
    for (int i = 0; i < 6; i++) add_row(tick_row(1'b1, 1'b0, '0));
    add_row(cfg_row(VB'(VMASK)));
    add_row(tick_row(1'b1, 1'b1, mk(1, 1048574, 1'b0, 0, 0)));
    for (int i = 0; i < 4; i++) add_row(tick_row(1'b1, 1'b0, '0));
    add_row(tick_row(1'b0, 1'b0, '0));
    add_row(cfg_row('0));
    add_row(tick_row(1'b1, 1'b1, mk(1, 1, 1'b0, 0, 0)));
    add_row(tick_row(1'b1, 1'b0, '0));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (rows[i]) begin
      if (rows[i].op == ROW_CFG) write_start(rows[i].cfg_value);
      else send_word(rows[i].adv, rows[i].typed, rows[i].want);
    end

    phase_start[0] = VB'(VMASK);
    phase_start[1] = '0;
    phase_start[2] = VB'($urandom);
    phase_start[3] = VB'(1);
    phase_start[4] = VB'(VMASK >> 1);
    for (int p = 0; p < 5; p++) begin
      write_start(phase_start[p]);
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 56; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 56; end
        default: begin idle_pct = 26; stall_pct = 26; end
      endcase
      done_ticks = 0;
      while (done_ticks < PER_PHASE) begin
        adv = ($urandom_range(9) != 0);
        // fill up the block with the receiver held off
        if (p == 0 && done_ticks == 50) hold_req = 1'b1;
        send_word(adv, 1'b0, '0);
        if (adv) done_ticks++;
      end
    end

    @(negedge clk);
    in_valid  = 1'b0;
    cur_typed = 1'b0;
    stall_pct = 0;
    while (expect_q.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);
    if (!failed) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
